@@ hw/rtl/assert_macros.svh @@
// Assertion helper macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, masked while reset is asserted.
`define KTC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent check that also holds through reset.
`define KTC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/ktc_pkg.sv @@
// Shared types and constants for the two-class nearest-neighbour classifier.
`timescale 1ns / 1ps
`default_nettype none
package ktc_pkg;

  localparam int COORD_W = 16;
  localparam int DIST_W  = 33;
  localparam int VOTE_W  = 7;
  localparam int NC_W    = 7;

  localparam logic [1:0] ACT_CLEAR    = 2'd0;
  localparam logic [1:0] ACT_LOAD     = 2'd1;
  localparam logic [1:0] ACT_CLASSIFY = 2'd2;

  localparam logic            REG_NEIGHBOUR_COUNT = 1'b0;
  localparam logic [NC_W-1:0] NC_RESET            = 7'd3;

  // One stored training point.
  typedef struct packed {
    logic                      grp;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
  } point_t;

  // Distance sample headed for the nearest list.
  typedef struct packed {
    logic              valid;
    logic              grp;
    logic [DIST_W-1:0] dist_sq;
  } dist_item_t;

endpackage
`default_nettype wire

@@ hw/rtl/ktc_if.sv @@
// Valid/ready channel interfaces for query items and classification results.
`timescale 1ns / 1ps
`default_nettype none
interface ktc_in_if import ktc_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [1:0]                action;
  logic signed [COORD_W-1:0] coord_x;
  logic signed [COORD_W-1:0] coord_y;
  logic                      group_label;

  modport source (output valid, action, coord_x, coord_y, group_label, input ready);
  modport sink   (input valid, action, coord_x, coord_y, group_label, output ready);
endinterface

interface ktc_out_if import ktc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              predicted_group;
  logic [VOTE_W-1:0] votes_zero;
  logic [VOTE_W-1:0] votes_one;

  modport source (output valid, predicted_group, votes_zero, votes_one, input ready);
  modport sink   (input valid, predicted_group, votes_zero, votes_one, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/ktc_point_mem.sv @@
// Training point store: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module ktc_point_mem import ktc_pkg::*; #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire point_t        wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output point_t             rd_data,
  output logic               rd_valid
);

  point_t mem [DEPTH];
  point_t rd_data_r;
  logic   rd_valid_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_valid_r <= 1'b0;
    end else begin
      rd_valid_r <= rd_en;
    end
  end

  assign rd_data  = rd_data_r;
  assign rd_valid = rd_valid_r;

endmodule
`default_nettype wire

@@ hw/rtl/ktc_dist_pipe.sv @@
// Three-stage squared-distance pipeline: difference, square, sum.
`timescale 1ns / 1ps
`default_nettype none
module ktc_dist_pipe import ktc_pkg::*; (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      pt_valid,
  input  wire point_t                    pt,
  input  wire logic signed [COORD_W-1:0] qx,
  input  wire logic signed [COORD_W-1:0] qy,
  output dist_item_t                     ins,
  output logic                           busy
);

  // stage 1: differences
  logic                      s1_v_r;
  logic                      s1_g_r;
  logic signed [COORD_W:0]   dx_r, dy_r, dx_nxt, dy_nxt;
  // stage 2: squares
  logic                      s2_v_r;
  logic                      s2_g_r;
  logic [31:0]               sqx_r, sqy_r;
  logic signed [2*COORD_W+1:0] sqx_full, sqy_full;
  // stage 3: sum
  logic                      s3_v_r;
  logic                      s3_g_r;
  logic [DIST_W-1:0]         dist_r, dist_nxt;

  always_comb begin
    dx_nxt   = {pt.x[COORD_W-1], pt.x} - {qx[COORD_W-1], qx};
    dy_nxt   = {pt.y[COORD_W-1], pt.y} - {qy[COORD_W-1], qy};
    sqx_full = dx_r * dx_r;
    sqy_full = dy_r * dy_r;
    dist_nxt = {1'b0, sqx_r} + {1'b0, sqy_r};
  end

  always_ff @(posedge clk) begin
    dx_r   <= dx_nxt;
    dy_r   <= dy_nxt;
    s1_g_r <= pt.grp;
    sqx_r  <= sqx_full[31:0];
    sqy_r  <= sqy_full[31:0];
    s2_g_r <= s1_g_r;
    dist_r <= dist_nxt;
    s3_g_r <= s2_g_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      s1_v_r <= pt_valid;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  assign ins.valid   = s3_v_r;
  assign ins.grp     = s3_g_r;
  assign ins.dist_sq = dist_r;
  assign busy        = s1_v_r | s2_v_r | s3_v_r;

endmodule
`default_nettype wire

@@ hw/rtl/ktc_nearest_list.sv @@
// Sorted list of the k nearest samples with running group vote counts.
`timescale 1ns / 1ps
`default_nettype none
module ktc_nearest_list import ktc_pkg::*; #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int CW    = 7
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [CW-1:0] k,
  input  wire dist_item_t    ins,
  output logic [CW-1:0]      votes0,
  output logic [CW-1:0]      votes1
);

  logic              cell_v_r [DEPTH];
  logic              cell_g_r [DEPTH];
  logic [DIST_W-1:0] cell_d_r [DEPTH];
  logic              cell_v_nxt [DEPTH];
  logic              cell_g_nxt [DEPTH];
  logic [DIST_W-1:0] cell_d_nxt [DEPTH];

  logic              ge      [DEPTH];
  logic              prev_ge [DEPTH];
  logic              prev_v  [DEPTH];
  logic              prev_g  [DEPTH];
  logic [DIST_W-1:0] prev_d  [DEPTH];

  logic [CW-1:0] v0_r, v1_r, v0_nxt, v1_nxt;
  logic [CW-1:0] km1;
  logic [AW-1:0] tail;
  logic          do_ins, tail_in, evict;

  always_comb begin
    // ge: the new sample sorts at or before this cell (ties stay behind)
    for (int i = 0; i < DEPTH; i++) begin
      ge[i] = !(cell_v_r[i] && (cell_d_r[i] <= ins.dist_sq));
    end
    prev_ge[0] = 1'b0;
    prev_v[0]  = 1'b0;
    prev_g[0]  = 1'b0;
    prev_d[0]  = '0;
    for (int i = 1; i < DEPTH; i++) begin
      prev_ge[i] = ge[i-1];
      prev_v[i]  = cell_v_r[i-1];
      prev_g[i]  = cell_g_r[i-1];
      prev_d[i]  = cell_d_r[i-1];
    end

    do_ins  = ins.valid && (k != '0);
    km1     = k - CW'(1);
    tail    = km1[AW-1:0];
    tail_in = do_ins && ge[tail];
    evict   = tail_in && cell_v_r[tail];

    for (int i = 0; i < DEPTH; i++) begin
      cell_v_nxt[i] = cell_v_r[i];
      cell_g_nxt[i] = cell_g_r[i];
      cell_d_nxt[i] = cell_d_r[i];
      if (start) begin
        cell_v_nxt[i] = 1'b0;
      end else if (do_ins && (CW'(i) < k) && ge[i]) begin
        if (!prev_ge[i]) begin
          cell_v_nxt[i] = 1'b1;
          cell_g_nxt[i] = ins.grp;
          cell_d_nxt[i] = ins.dist_sq;
        end else begin
          cell_v_nxt[i] = prev_v[i];
          cell_g_nxt[i] = prev_g[i];
          cell_d_nxt[i] = prev_d[i];
        end
      end
    end

    v0_nxt = v0_r;
    v1_nxt = v1_r;
    if (start) begin
      v0_nxt = '0;
      v1_nxt = '0;
    end else begin
      if (tail_in) begin
        if (ins.grp) v1_nxt = v1_nxt + CW'(1);
        else         v0_nxt = v0_nxt + CW'(1);
      end
      if (evict) begin
        if (cell_g_r[tail]) v1_nxt = v1_nxt - CW'(1);
        else                v0_nxt = v0_nxt - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      cell_g_r[i] <= cell_g_nxt[i];
      cell_d_r[i] <= cell_d_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) begin
        cell_v_r[i] <= 1'b0;
      end
      v0_r <= '0;
      v1_r <= '0;
    end else begin
      for (int i = 0; i < DEPTH; i++) begin
        cell_v_r[i] <= cell_v_nxt[i];
      end
      v0_r <= v0_nxt;
      v1_r <= v1_nxt;
    end
  end

  assign votes0 = v0_r;
  assign votes1 = v1_r;

endmodule
`default_nettype wire

@@ hw/rtl/knn_two_class_classifier_top.sv @@
// Top level of the two-class nearest-neighbour classifier.
// Usage:
//   in_ch  (valid/ready) carries one item: action, coord_x, coord_y, group_label.
//     clear    - empties the store, no result.
//     load     - writes the point at the next free entry, no result;
//                dropped once MAX_POINTS points are held.
//     classify - one result item on out_ch: predicted_group, votes_zero,
//                votes_one.
//   A classify reads the point memory one entry per cycle through a
//   three-stage distance pipe into a sorted k-entry nearest list; once the
//   read path is empty the votes go to the result register, and only then
//   is the next item taken.
//   in_ch.ready is high only while no item is in flight.
//   APB port: register 0 at address 0 is neighbour_count (k), reset 3.
//   Write it only while the block is idle. pready is tied high.
//   Reset (rst_n low, synchronous) empties the store and drops any pending
//   result. Point memory holds no reset value.
//   A stalled out_ch holds the result; load and clear items are still taken,
//   and a finished classify waits until the previous result is taken.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module knn_two_class_classifier_top import ktc_pkg::*; #(
  parameter int MAX_POINTS = 64
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  ktc_in_if.sink     in_ch,
  ktc_out_if.source  out_ch,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int KW = (CW > NC_W) ? CW : NC_W;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DRAIN, S_FINISH} state_t;

  state_t                    state_r;
  logic [CW-1:0]             count_r;
  logic [CW-1:0]             k_r;
  logic [AW-1:0]             scan_addr_r;
  logic signed [COORD_W-1:0] qx_r, qy_r;
  logic [NC_W-1:0]           nc_r;
  logic                      out_valid_r;
  logic                      out_pred_r;
  logic [VOTE_W-1:0]         out_v0_r, out_v1_r;

  logic          in_take, cfg_wr, mem_wr, rd_en, pipe_busy, list_start, out_load;
  logic [CW-1:0] k_nxt;
  logic [KW-1:0] nc_ext, cnt_ext;
  point_t        wr_pt, rd_pt;
  logic          rd_valid;
  dist_item_t    ins;
  logic [CW-1:0] votes0, votes1;

  // -- handshake and decode --
  assign in_ch.ready = (state_r == S_IDLE);
  assign in_take     = in_ch.valid && in_ch.ready;
  assign mem_wr      = in_take && (in_ch.action == ACT_LOAD) &&
                       (count_r < CW'(MAX_POINTS));
  assign list_start  = in_take && (in_ch.action == ACT_CLASSIFY);
  assign rd_en       = (state_r == S_SCAN);
  // result register takes a finished classify once it is free or being emptied
  assign out_load    = (state_r == S_FINISH) && (!out_valid_r || out_ch.ready);

  assign wr_pt.grp = in_ch.group_label;
  assign wr_pt.x   = in_ch.coord_x;
  assign wr_pt.y   = in_ch.coord_y;

  // k is capped at the stored count
  assign nc_ext  = KW'(nc_r);
  assign cnt_ext = KW'(count_r);
  assign k_nxt   = (nc_ext < cnt_ext) ? CW'(nc_r) : count_r;

  // -- APB register port --
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_NEIGHBOUR_COUNT);
  assign prdata = (paddr[2] == REG_NEIGHBOUR_COUNT) ? {25'd0, nc_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nc_r <= NC_RESET;
    end else if (cfg_wr) begin
      nc_r <= pwdata[NC_W-1:0];
    end
  end

  // -- control sequencer and result register --
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      k_r         <= '0;
      scan_addr_r <= '0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_take) begin
            case (in_ch.action)
              ACT_CLEAR: count_r <= '0;
              ACT_LOAD: begin
                if (mem_wr) count_r <= count_r + CW'(1);
              end
              ACT_CLASSIFY: begin
                qx_r        <= in_ch.coord_x;
                qy_r        <= in_ch.coord_y;
                k_r         <= k_nxt;
                scan_addr_r <= '0;
                state_r     <= (count_r == '0) ? S_DRAIN : S_SCAN;
              end
              default: ;
            endcase
          end
        end
        S_SCAN: begin
          scan_addr_r <= scan_addr_r + AW'(1);
          if (CW'(scan_addr_r) == count_r - CW'(1)) begin
            state_r <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          // list is final once nothing is left in the read path
          if (!rd_valid && !pipe_busy) begin
            state_r <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_load) begin
            out_pred_r  <= (votes0 > votes1) ? 1'b0 : 1'b1;
            out_v0_r    <= VOTE_W'(votes0);
            out_v1_r    <= VOTE_W'(votes1);
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.predicted_group = out_pred_r;
  assign out_ch.votes_zero      = out_v0_r;
  assign out_ch.votes_one       = out_v1_r;

  // -- datapath --
  ktc_point_mem #(.DEPTH(MAX_POINTS), .AW(AW)) u_mem (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (mem_wr),
    .wr_addr  (count_r[AW-1:0]),
    .wr_data  (wr_pt),
    .rd_en    (rd_en),
    .rd_addr  (scan_addr_r),
    .rd_data  (rd_pt),
    .rd_valid (rd_valid)
  );

  ktc_dist_pipe u_dist (
    .clk      (clk),
    .rst_n    (rst_n),
    .pt_valid (rd_valid),
    .pt       (rd_pt),
    .qx       (qx_r),
    .qy       (qy_r),
    .ins      (ins),
    .busy     (pipe_busy)
  );

  ktc_nearest_list #(.DEPTH(MAX_POINTS), .AW(AW), .CW(CW)) u_list (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (list_start),
    .k      (k_r),
    .ins    (ins),
    .votes0 (votes0),
    .votes1 (votes1)
  );

  // -- checks --
  `KTC_ASSERT(a_scan_in_range, clk, rst_n, (state_r == S_SCAN) |-> (CW'(scan_addr_r) < count_r), "scan address past stored count")
  `KTC_ASSERT(a_ins_busy, clk, rst_n, ins.valid |-> (state_r == S_SCAN || state_r == S_DRAIN), "list insert outside classify")
  `KTC_ASSERT(a_out_from_finish, clk, rst_n, $rose(out_valid_r) |-> $past(state_r == S_FINISH), "result without finished classify")
  `KTC_ASSERT(a_votes_le_k, clk, rst_n, (state_r == S_FINISH) |-> ((KW+1)'(votes0) + (KW+1)'(votes1) == (KW+1)'(k_r)), "vote total differs from k")

endmodule
`default_nettype wire

@@ test/tb_top.sv @@
// Self-checking testbench for the two-class nearest-neighbour classifier top level.
`timescale 1ns / 1ps
module tb_top;
  import ktc_pkg::*;

  localparam int MAX_POINTS = 64;
  // Settling wait, a little longer than the worst-case classify.
  localparam int SETTLE_CYCLES = MAX_POINTS + 16;
  // Long result hold-off so the block fills up and stalls its input.
  localparam int HOLD_CYCLES = 400;
  // Cycles without any handshake before the run is declared hung.
  localparam int STALL_LIMIT = 4000;
  localparam int RANDOM_ITEMS = 600;

  // The package defines no name for the spare action code.
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  localparam logic signed [COORD_W-1:0] COORD_MAX = 16'sh7FFF;
  localparam logic signed [COORD_W-1:0] COORD_MIN = 16'sh8000;

  typedef struct packed {
    logic              predicted_group;
    logic [VOTE_W-1:0] votes_zero;
    logic [VOTE_W-1:0] votes_one;
  } vote_result_t;

  logic        clk     = 1'b0;
  logic        rst_n   = 1'b0;
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [2:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;

  ktc_in_if  in_ch();
  ktc_out_if out_ch();

  knn_two_class_classifier_top #(.MAX_POINTS(MAX_POINTS)) DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow copy of the point store and k, updated as items are accepted.
  logic signed [COORD_W-1:0] shadow_x   [MAX_POINTS];
  logic signed [COORD_W-1:0] shadow_y   [MAX_POINTS];
  logic                      shadow_grp [MAX_POINTS];
  int unsigned               shadow_count;
  logic [NC_W-1:0]           shadow_k;

  // Votes still owed by the block, oldest first.
  vote_result_t pending_votes[$];

  int  error_count     = 0;
  int  results_checked = 0;
  int  items_sent      = 0;
  int  loads_dropped   = 0;
  int  k_writes        = 0;
  int  quiet_cycles    = 0;
  bit  idle_on         = 1'b1;
  bit  hold_results    = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Exact squared distances, rank by (distance, load order), then vote.
  function automatic vote_result_t nearest_vote(input logic signed [COORD_W-1:0] qx,
                                                input logic signed [COORD_W-1:0] qy);
    logic [DIST_W-1:0] sq_d [MAX_POINTS];
    longint            dx, dy;
    int unsigned       k, rank, v0, v1;
    vote_result_t      r;
    k  = (shadow_k < shadow_count) ? shadow_k : shadow_count;
    v0 = 0;
    v1 = 0;
    for (int i = 0; i < shadow_count; i++) begin
      dx      = longint'(shadow_x[i]) - longint'(qx);
      dy      = longint'(shadow_y[i]) - longint'(qy);
      sq_d[i] = DIST_W'(dx * dx + dy * dy);
    end
    for (int i = 0; i < shadow_count; i++) begin
      rank = 0;
      for (int j = 0; j < shadow_count; j++) begin
        if (sq_d[j] < sq_d[i] || (sq_d[j] == sq_d[i] && j < i)) rank++;
      end
      if (rank < k) begin
        if (shadow_grp[i] == 1'b0) v0++;
        else v1++;
      end
    end
    r.predicted_group = (v0 > v1) ? 1'b0 : 1'b1;
    r.votes_zero      = VOTE_W'(v0);
    r.votes_one       = VOTE_W'(v1);
    return r;
  endfunction

  function automatic void apply_item(input logic [1:0] act,
                                     input logic signed [COORD_W-1:0] x,
                                     input logic signed [COORD_W-1:0] y,
                                     input logic g);
    case (act)
      ACT_CLEAR: begin
        shadow_count = 0;
      end
      ACT_LOAD: begin
        if (shadow_count < MAX_POINTS) begin
          shadow_x[shadow_count]   = x;
          shadow_y[shadow_count]   = y;
          shadow_grp[shadow_count] = g;
          shadow_count++;
        end else begin
          loads_dropped++;
        end
      end
      ACT_CLASSIFY: begin
        pending_votes.push_back(nearest_vote(x, y));
      end
      default: ;
    endcase
  endfunction

  // Full-range values, some extremes, and mostly a tight cluster near the
  // origin so equal distances show up often.
  function automatic logic signed [COORD_W-1:0] pick_coord();
    case ($urandom_range(0, 5))
      0, 1: return COORD_W'($urandom);
      2: return $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
      default: return COORD_W'($urandom_range(0, 24) - 12);
    endcase
  endfunction

  // Drive one item at a falling edge and hold it until accepted. Valid is
  // left high afterwards; the next call or drain_and_settle decides.
  task automatic send_item(input logic [1:0] act,
                           input logic signed [COORD_W-1:0] x,
                           input logic signed [COORD_W-1:0] y,
                           input logic g);
    int gap;
    gap = idle_on ? $urandom_range(0, 6) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.action      <= act;
    in_ch.coord_x     <= x;
    in_ch.coord_y     <= y;
    in_ch.group_label <= g;
    do @(posedge clk); while (!in_ch.ready);
    apply_item(act, x, y, g);
    if (act != ACT_UNUSED) items_sent++;
  endtask

  task automatic drain_and_settle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_votes.size() != 0) @(negedge clk);
    // loads and clears leave nothing to wait for, so give the pipe time to empty
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // APB write of k followed by a read-back, always with the block idle.
  task automatic write_neighbour_count(input logic [NC_W-1:0] k);
    logic [31:0] readback;
    drain_and_settle();
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(4 * int'(REG_NEIGHBOUR_COUNT));
    pwdata  <= 32'(k);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    shadow_k = k;
    k_writes++;
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    readback = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (readback[NC_W-1:0] !== k) begin
      error_count++;
      $display("%0t: neighbour_count read-back mismatch, expected %0d, actual %0d",
               $time, k, readback[NC_W-1:0]);
    end
  endtask

  // Result side: random stalls per item, plus one long hold-off on request.
  initial begin : result_sink
    int gap;
    out_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_results) begin
        out_ch.ready <= 1'b0;
        for (int held = 0; held < HOLD_CYCLES; held++) @(negedge clk);
        hold_results = 1'b0;
      end else begin
        gap = idle_on ? $urandom_range(0, 6) : 0;
        if (gap > 0) begin
          out_ch.ready <= 1'b0;
          repeat (gap) @(negedge clk);
        end
        out_ch.ready <= 1'b1;
        do @(posedge clk); while (!out_ch.valid);
        @(negedge clk);
      end
    end
  end

  // Compare every accepted result with the oldest outstanding prediction.
  always @(posedge clk) begin : check_results
    vote_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_votes.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result, expected none, actual group %0d votes %0d/%0d",
                 $time, out_ch.predicted_group, out_ch.votes_zero, out_ch.votes_one);
      end else begin
        want = pending_votes.pop_front();
        results_checked++;
        if (out_ch.predicted_group !== want.predicted_group) begin
          error_count++;
          $display("%0t: predicted_group mismatch, expected %0d, actual %0d",
                   $time, want.predicted_group, out_ch.predicted_group);
        end
        if (out_ch.votes_zero !== want.votes_zero) begin
          error_count++;
          $display("%0t: votes_zero mismatch, expected %0d, actual %0d",
                   $time, want.votes_zero, out_ch.votes_zero);
        end
        if (out_ch.votes_one !== want.votes_one) begin
          error_count++;
          $display("%0t: votes_one mismatch, expected %0d, actual %0d",
                   $time, want.votes_one, out_ch.votes_one);
        end
      end
    end
  end

  // Hang detector: any handshake on any port resets the count.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
      $display("tb_top: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Empty store (k at reset value), the spare action, and a clear with nothing stored.
  task automatic test_empty_store();
    send_item(ACT_CLASSIFY, 16'sd0, 16'sd0, 1'b0);
    send_item(ACT_UNUSED, COORD_MAX, COORD_MIN, 1'b1);
    send_item(ACT_CLEAR, COORD_MIN, COORD_MAX, 1'b1);
    send_item(ACT_CLASSIFY, COORD_MIN, COORD_MAX, 1'b1);
  endtask

  // Corner coordinates (largest distances), then four points at equal
  // distance from the origin so the load order breaks the tie.
  task automatic test_extremes_and_ties();
    send_item(ACT_LOAD, COORD_MIN, COORD_MIN, 1'b0);
    send_item(ACT_LOAD, COORD_MAX, COORD_MAX, 1'b1);
    send_item(ACT_LOAD, COORD_MAX, COORD_MIN, 1'b1);
    send_item(ACT_LOAD, COORD_MIN, COORD_MAX, 1'b0);
    send_item(ACT_CLASSIFY, COORD_MIN, COORD_MIN, 1'b0);
    send_item(ACT_CLASSIFY, COORD_MAX, COORD_MAX, 1'b1);
    send_item(ACT_CLASSIFY, 16'sd0, 16'sd0, 1'b0);
    send_item(ACT_CLEAR, 16'sd0, 16'sd0, 1'b0);
    send_item(ACT_LOAD, 16'sd16, 16'sd0, 1'b1);
    send_item(ACT_LOAD, -16'sd16, 16'sd0, 1'b0);
    send_item(ACT_LOAD, 16'sd0, 16'sd16, 1'b0);
    send_item(ACT_LOAD, 16'sd0, -16'sd16, 1'b1);
    send_item(ACT_CLASSIFY, 16'sd0, 16'sd0, 1'b0);
    send_item(ACT_CLASSIFY, 16'sd16, 16'sd0, 1'b1);
  endtask

  // k of 1 (tie goes to the first point), 0 (no voters), 127 and 64 (capped
  // at the stored count, a 2/2 vote that falls to group 1), then back to 3.
  task automatic test_neighbour_counts();
    write_neighbour_count(7'd1);
    send_item(ACT_CLASSIFY, 16'sd0, 16'sd0, 1'b0);
    write_neighbour_count(7'd0);
    send_item(ACT_CLASSIFY, 16'sd0, 16'sd0, 1'b0);
    write_neighbour_count(7'd127);
    send_item(ACT_CLASSIFY, 16'sd0, 16'sd0, 1'b0);
    write_neighbour_count(7'd64);
    send_item(ACT_CLASSIFY, 16'sd1, 16'sd0, 1'b0);
    write_neighbour_count(NC_RESET);
  endtask

  // Fill past capacity so the last loads are dropped, then vote with all 64 and with 63.
  task automatic test_full_store();
    idle_on = 1'b0;
    write_neighbour_count(7'd64);
    send_item(ACT_CLEAR, pick_coord(), pick_coord(), 1'($urandom));
    repeat (MAX_POINTS + 6) send_item(ACT_LOAD, pick_coord(), pick_coord(), 1'($urandom));
    repeat (6) send_item(ACT_CLASSIFY, pick_coord(), pick_coord(), 1'($urandom));
    idle_on = 1'b1;
    write_neighbour_count(7'd63);
    repeat (6) send_item(ACT_CLASSIFY, pick_coord(), pick_coord(), 1'($urandom));
  endtask

  // Results held off while items keep coming: loads and clears go through,
  // the classifies back up until the input stalls.
  task automatic test_result_backpressure();
    idle_on = 1'b0;
    write_neighbour_count(7'd5);
    repeat (10) send_item(ACT_LOAD, pick_coord(), pick_coord(), 1'($urandom));
    hold_results = 1'b1;
    send_item(ACT_CLASSIFY, pick_coord(), pick_coord(), 1'b0);
    send_item(ACT_CLASSIFY, pick_coord(), pick_coord(), 1'b0);
    send_item(ACT_LOAD, pick_coord(), pick_coord(), 1'b1);
    send_item(ACT_CLASSIFY, pick_coord(), pick_coord(), 1'b0);
    send_item(ACT_LOAD, pick_coord(), pick_coord(), 1'b0);
    send_item(ACT_CLASSIFY, pick_coord(), pick_coord(), 1'b1);
    send_item(ACT_CLEAR, pick_coord(), pick_coord(), 1'b0);
    send_item(ACT_CLASSIFY, pick_coord(), pick_coord(), 1'b1);
    send_item(ACT_LOAD, pick_coord(), pick_coord(), 1'b1);
    send_item(ACT_CLASSIFY, pick_coord(), pick_coord(), 1'b0);
    idle_on = 1'b1;
  endtask

  // Sessions of: maybe a new k, maybe a clear, a batch of loads, then queries
  // with the odd stray load, clear or spare action mixed in.
  task automatic test_random_sessions();
    int goal, loads, queries;
    goal = items_sent + RANDOM_ITEMS;
    while (items_sent < goal) begin
      idle_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 7))
          0: write_neighbour_count(7'd0);
          1: write_neighbour_count(7'd1);
          2: write_neighbour_count(7'd64);
          3: write_neighbour_count(7'd127);
          4: write_neighbour_count(NC_W'($urandom));
          default: write_neighbour_count(NC_W'($urandom_range(1, 64)));
        endcase
      end
      if ($urandom_range(0, 3) != 0) begin
        send_item(ACT_CLEAR, pick_coord(), pick_coord(), 1'($urandom));
      end
      loads = ($urandom_range(0, 7) == 0) ? $urandom_range(56, 72) : $urandom_range(0, 20);
      repeat (loads) send_item(ACT_LOAD, pick_coord(), pick_coord(), 1'($urandom));
      queries = $urandom_range(4, 24);
      repeat (queries) begin
        case ($urandom_range(0, 19))
          0: send_item(ACT_UNUSED, pick_coord(), pick_coord(), 1'($urandom));
          1: send_item(ACT_LOAD, pick_coord(), pick_coord(), 1'($urandom));
          2: send_item(ACT_CLEAR, pick_coord(), pick_coord(), 1'($urandom));
          default: send_item(ACT_CLASSIFY, pick_coord(), pick_coord(), 1'($urandom));
        endcase
      end
    end
    idle_on = 1'b1;
  endtask

  initial begin
    in_ch.valid       = 1'b0;
    in_ch.action      = ACT_CLEAR;
    in_ch.coord_x     = '0;
    in_ch.coord_y     = '0;
    in_ch.group_label = 1'b0;
    shadow_count      = 0;
    shadow_k          = NC_RESET;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_store();
    test_extremes_and_ties();
    test_neighbour_counts();
    test_full_store();
    test_result_backpressure();
    test_random_sessions();

    drain_and_settle();
    $display("Run covered %0d items and %0d checked votes over %0d k settings;",
             items_sent, results_checked, k_writes);
    $display("  %0d loads fell on a full store, %0d mismatches.", loads_dropped, error_count);
    if (error_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/ktc_pkg.sv
hw/rtl/ktc_if.sv
hw/rtl/ktc_point_mem.sv
hw/rtl/ktc_dist_pipe.sv
hw/rtl/ktc_nearest_list.sv
hw/rtl/knn_two_class_classifier_top.sv
test/tb_top.sv
